/* design/aes128_pkg.sv */
// aes128_pkg: shared types, constants and round functions for the aes-128 encrypt unit
// used by aes128_ctrl, aes128_dp and aes128_block_encrypt_unit; no dependencies

package aes128_pkg;

	localparam int unsigned BLK_W     = 128;
	localparam int unsigned HALF_W    = 64;
	localparam int unsigned RND_W     = 4;
	localparam int unsigned CFG_IDX_W = 8;

	localparam logic [RND_W-1:0] NUM_ROUNDS = RND_W'(10);
	localparam logic [RND_W-1:0] FIRST_RND  = RND_W'(1);

	localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = CFG_IDX_W'(1);

	localparam logic [7:0] POLY_LOW  = 8'h1b;
	localparam logic [7:0] RCON_INIT = 8'h01;

	typedef struct packed {
		logic [HALF_W-1:0] plaintext_high;
		logic [HALF_W-1:0] plaintext_low;
	} pt_t;

	typedef struct packed {
		logic [HALF_W-1:0] cipher_high;
		logic [HALF_W-1:0] cipher_low;
	} ct_t;

	typedef struct packed {
		logic load;
		logic step;
		logic last;
	} cmd_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_RUN
	} fsm_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] b);
		logic [7:0] d;
		d = {b[6:0], 1'b0};
		if (b[7]) begin
			d = d ^ POLY_LOW;
		end
		return d;
	endfunction

	function automatic logic [31:0] mix_col(input logic [31:0] a);
		logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3;
		a0 = a[31:24];
		a1 = a[23:16];
		a2 = a[15:8];
		a3 = a[7:0];
		x0 = xtime(a0);
		x1 = xtime(a1);
		x2 = xtime(a2);
		x3 = xtime(a3);
		return {x0 ^ x1 ^ a1 ^ a2 ^ a3,
			a0 ^ x1 ^ x2 ^ a2 ^ a3,
			a0 ^ a1 ^ x2 ^ x3 ^ a3,
			x0 ^ a0 ^ a1 ^ a2 ^ x3};
	endfunction

	function automatic logic [BLK_W-1:0] key_step(input logic [BLK_W-1:0] rk,
			input logic [7:0] rcon);
		logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
		w0 = rk[127:96];
		w1 = rk[95:64];
		w2 = rk[63:32];
		w3 = rk[31:0];
		t = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
		n0 = w0 ^ t;
		n1 = w1 ^ n0;
		n2 = w2 ^ n1;
		n3 = w3 ^ n2;
		return {n0, n1, n2, n3};
	endfunction

	function automatic logic [BLK_W-1:0] enc_round(input logic [BLK_W-1:0] s,
			input logic [BLK_W-1:0] rk, input logic last);
		logic [7:0] b [16];
		logic [7:0] t [16];
		logic [31:0] col;
		logic [BLK_W-1:0] m;
		m = '0;
		for (int k = 0; k < 16; k++) begin
			b[k] = s[BLK_W-1-8*k -: 8];
		end
		// sub bytes and shift rows
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[c*4+r] = SBOX[b[((c + r) & 3) * 4 + r]];
			end
		end
		for (int c = 0; c < 4; c++) begin
			col = {t[c*4], t[c*4+1], t[c*4+2], t[c*4+3]};
			m[BLK_W-1-32*c -: 32] = last ? col : mix_col(col);
		end
		return m ^ rk;
	endfunction

endpackage

/* design/aes128_ctrl.sv */
// aes128_ctrl: round sequencer and result handshake for the aes-128 encrypt unit
// depends on aes128_pkg; drives commands into aes128_dp

module aes128_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pt_valid,
	output logic                pt_stall,
	output logic                ct_valid,
	input  logic                ct_stall,
	output aes128_pkg::cmd_t    cmd
);

	aes128_pkg::fsm_t fsm_q, fsm_d;
	logic [aes128_pkg::RND_W-1:0] rnd_q, rnd_d;
	logic ct_valid_q, ct_valid_d;
	logic out_free;
	logic capture;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q      <= aes128_pkg::ST_IDLE;
			rnd_q      <= '0;
			ct_valid_q <= 1'b0;
		end else begin
			fsm_q      <= fsm_d;
			rnd_q      <= rnd_d;
			ct_valid_q <= ct_valid_d;
		end
	end

	assign out_free = !ct_valid_q || !ct_stall;

	always_comb begin
		fsm_d    = fsm_q;
		rnd_d    = rnd_q;
		cmd      = '0;
		pt_stall = 1'b1;
		capture  = 1'b0;
		case (fsm_q)
			aes128_pkg::ST_IDLE: begin
				pt_stall = 1'b0;
				if (pt_valid) begin
					cmd.load = 1'b1;
					rnd_d    = aes128_pkg::FIRST_RND;
					fsm_d    = aes128_pkg::ST_RUN;
				end
			end
			aes128_pkg::ST_RUN: begin
				cmd.last = (rnd_q == aes128_pkg::NUM_ROUNDS);
				// final round waits for the output register
				if (!cmd.last) begin
					cmd.step = 1'b1;
					rnd_d    = rnd_q + aes128_pkg::RND_W'(1);
				end else if (out_free) begin
					cmd.step = 1'b1;
					capture  = 1'b1;
					fsm_d    = aes128_pkg::ST_IDLE;
				end
			end
			default: begin
				fsm_d = aes128_pkg::ST_IDLE;
			end
		endcase
		ct_valid_d = capture || (ct_valid_q && ct_stall);
	end

	assign ct_valid = ct_valid_q;

`ifndef SYNTHESIS
	a_load_starts_first_round: assert property (@(posedge clk) disable iff (!arst_n)
		(pt_valid && !pt_stall) |=> (fsm_q == aes128_pkg::ST_RUN
			&& rnd_q == aes128_pkg::FIRST_RND))
		else $error("accepted item did not start the first round");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		capture |-> (!ct_valid_q || !ct_stall))
		else $error("result captured over a waiting item");

	a_round_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(fsm_q == aes128_pkg::ST_RUN) |-> (rnd_q >= aes128_pkg::FIRST_RND
			&& rnd_q <= aes128_pkg::NUM_ROUNDS))
		else $error("round index out of range");

	a_capture_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		capture |=> (ct_valid_q && fsm_q == aes128_pkg::ST_IDLE))
		else $error("captured result not presented");
`endif

endmodule

/* design/aes128_dp.sv */
// aes128_dp: key registers, state and round key registers, round unit and output register
// depends on aes128_pkg; sequenced by aes128_ctrl

module aes128_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [aes128_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [aes128_pkg::HALF_W-1:0]       cfg_data,
	input  aes128_pkg::pt_t                     pt,
	input  aes128_pkg::cmd_t                    cmd,
	output aes128_pkg::ct_t                     ct
);

	logic [aes128_pkg::HALF_W-1:0] key_high_q, key_low_q;
	logic [aes128_pkg::BLK_W-1:0]  state_q, rk_q, rk_nx, st_nx, key_full;
	logic [7:0]                    rcon_q;
	aes128_pkg::ct_t               ct_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				aes128_pkg::CFG_KEY_HIGH: key_high_q <= cfg_data;
				aes128_pkg::CFG_KEY_LOW:  key_low_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign key_full = {key_high_q, key_low_q};
	assign rk_nx    = aes128_pkg::key_step(rk_q, rcon_q);
	assign st_nx    = aes128_pkg::enc_round(state_q, rk_nx, cmd.last);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			state_q <= pt ^ key_full;
			rk_q    <= key_full;
			rcon_q  <= aes128_pkg::RCON_INIT;
		end else if (cmd.step) begin
			state_q <= st_nx;
			rk_q    <= rk_nx;
			rcon_q  <= aes128_pkg::xtime(rcon_q);
			if (cmd.last) begin
				ct_q <= st_nx;
			end
		end
	end

	assign ct = ct_q;

endmodule

/* design/aes128_block_encrypt_unit.sv */
// aes128_block_encrypt_unit: aes-128 encryption of one 128-bit block per item
// rounds run one per cycle once an item is accepted, save where the final round holds for the output
// one item at a time: a new item is taken only after the final round of the last, set by the single shared round unit
// and on-the-fly key schedule; the result waits in an output register; the next item is taken while it waits
// the final round holds while a previous result is still stalled at the output
// reset clears the sequencer, output valid and both key registers to zero

module aes128_block_encrypt_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pt_valid,
	output logic                                pt_stall,
	input  aes128_pkg::pt_t                     pt,
	output logic                                ct_valid,
	input  logic                                ct_stall,
	output aes128_pkg::ct_t                     ct,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [aes128_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [aes128_pkg::HALF_W-1:0]       cfg_data
);

	aes128_pkg::cmd_t cmd;

	assign cfg_ready = 1'b1;

	aes128_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.pt_valid (pt_valid),
		.pt_stall (pt_stall),
		.ct_valid (ct_valid),
		.ct_stall (ct_stall),
		.cmd      (cmd)
	);

	aes128_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pt        (pt),
		.cmd       (cmd),
		.ct        (ct)
	);

endmodule
